// ===== rtl/bmprle_pkg.sv =====
// Shared types, constants and helpers for the BMP RLE8/RLE4 decoder.
`default_nettype none

package bmprle_pkg;

    localparam int MAX_DIM = 4096;
    // Dimensions are clamped to 1..min(MAX_DIM, 4096)
    localparam logic [12:0] DIM_CAP = 13'((MAX_DIM < 4096) ? MAX_DIM : 4096);

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_WIDTH  = 4'h0;
    localparam logic [ADDR_W-1:0] REG_HEIGHT = 4'h4;
    localparam logic [ADDR_W-1:0] REG_NIBBLE = 4'h8;

    typedef struct packed {
        logic [12:0] width;   // clamped
        logic [12:0] height;  // clamped
        logic        nibble;
    } t_cfg;

    typedef struct packed {
        logic [11:0] row_index;
        logic [11:0] column_start;
        logic [7:0]  first_value;
        logic [3:0]  second_value;
        logic [7:0]  run_length;
        logic        alternating;
        logic        was_clipped;
        logic        frame_done;
    } t_result;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > DIM_CAP) begin
            r = DIM_CAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bmp_rle_decoder.sv =====
// Top level of the BMP RLE8/RLE4 stream decoder.
// Takes one compressed byte per beat and produces at most one pixel-run beat per
// input byte; a new byte is accepted every cycle, since each byte is parsed by
// combinational logic and results pass through a two-entry output buffer (output
// register plus skid), so input stalls only when both entries are full. Runs are
// registered into the output register, or into the skid while it is held. Set
// width, height and mode over APB while idle, and mark the first byte of each
// frame with frame_start. Frame clearing is up to the consumer; a frame_done beat
// closes the frame and later bytes are dropped until the next frame_start.
`default_nettype none

module bmp_rle_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [bmprle_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] frame_start
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [11:0] row_index, [23:12] column_start, [31:24] first_value,
    // [35:32] second_value, [43:36] run_length, [44] alternating,
    // [45] was_clipped, [47:46] zero
    output logic [47:0]      o_m_tdata,
    output logic [0:0]       o_m_tuser    // [0] frame_done
);
    import bmprle_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    core_valid;
    logic    accept;

    bmprle_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept = i_s_tvalid && o_s_tready;

    bmprle_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_data_byte   (i_s_tdata),
        .i_frame_start (i_s_tuser[0]),
        .o_res_valid   (core_valid),
        .o_res         (core_res)
    );

    bmprle_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && core_valid),
        .i_res   (core_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_take  (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {2'b00,
                        out_res.was_clipped,
                        out_res.alternating,
                        out_res.run_length,
                        out_res.second_value,
                        out_res.first_value,
                        out_res.column_start,
                        out_res.row_index};
    assign o_m_tuser = out_res.frame_done;

endmodule

`default_nettype wire

// ===== rtl/bmprle_cfg.sv =====
// APB register file holding image width, height and nibble mode.
`default_nettype none

module bmprle_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bmprle_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output bmprle_pkg::t_cfg                o_cfg
);
    import bmprle_pkg::*;

    logic [12:0] r_width;
    logic [12:0] r_height;
    logic        r_nibble;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 13'd1;
            r_nibble <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr)
                REG_WIDTH:  r_width  <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                REG_NIBBLE: r_nibble <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            REG_NIBBLE: prdata = {31'd0, r_nibble};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.width  = clamp_dim(r_width);
    assign o_cfg.height = clamp_dim(r_height);
    assign o_cfg.nibble = r_nibble;

endmodule

`default_nettype wire

// ===== rtl/bmprle_core.sv =====
// Per-byte RLE parser: state registers and the combinational next-state/result logic.
`default_nettype none

module bmprle_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bmprle_pkg::t_cfg    i_cfg,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_frame_start,
    output logic                     o_res_valid,
    output bmprle_pkg::t_result      o_res
);
    import bmprle_pkg::*;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_ESC,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_row, n_row;
    logic [12:0] r_col, n_col;
    logic [7:0]  r_run, n_run;
    logic [7:0]  r_dx, n_dx;
    logic        r_pad, n_pad;
    logic        r_done, n_done;

    always_comb begin
        t_phase      e_phase;
        logic [11:0] e_row;
        logic [12:0] e_col;
        logic [7:0]  e_run;
        logic [7:0]  e_dx;
        logic        e_pad;
        logic        e_done;
        logic        do_run;
        logic        do_done;
        logic [7:0]  cnt;
        logic [7:0]  fv;
        logic [3:0]  sv;
        logic        alt;
        logic [7:0]  n_abs;
        logic [12:0] w;
        logic [12:0] col_c;
        logic [12:0] avail;
        logic [12:0] cnt_x;
        logic [7:0]  len;
        logic [13:0] nc;
        logic [8:0]  b_inc;
        logic [3:0]  hi;
        logic [3:0]  lo;

        w     = i_cfg.width;
        hi    = i_data_byte[7:4];
        lo    = i_data_byte[3:0];
        b_inc = {1'b0, i_data_byte} + 9'd1;

        // frame_start restarts, then the byte is decoded as the first of the frame
        if (i_frame_start) begin
            e_phase = PH_COUNT;
            e_row   = 12'(i_cfg.height - 13'd1);
            e_col   = '0;
            e_run   = '0;
            e_dx    = '0;
            e_pad   = 1'b0;
            e_done  = 1'b0;
        end else begin
            e_phase = r_phase;
            e_row   = r_row;
            e_col   = r_col;
            e_run   = r_run;
            e_dx    = r_dx;
            e_pad   = r_pad;
            e_done  = r_done;
        end

        n_phase = e_phase;
        n_row   = e_row;
        n_col   = e_col;
        n_run   = e_run;
        n_dx    = e_dx;
        n_pad   = e_pad;
        n_done  = e_done;
        do_run  = 1'b0;
        do_done = 1'b0;
        cnt     = '0;
        fv      = '0;
        sv      = '0;
        alt     = 1'b0;
        n_abs   = '0;
        nc      = '0;

        if (!e_done) begin
            unique case (e_phase)
                PH_COUNT: begin
                    if (i_data_byte != 8'd0) begin
                        n_run   = i_data_byte;
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end
                PH_VALUE: begin
                    n_phase = PH_COUNT;
                    do_run  = 1'b1;
                    cnt     = e_run;
                    if (i_cfg.nibble) begin
                        fv  = {4'd0, hi};
                        sv  = lo;
                        alt = 1'b1;
                    end else begin
                        fv  = i_data_byte;
                    end
                end
                PH_ESC: begin
                    if (i_data_byte == 8'd0) begin
                        // end of line
                        n_col = '0;
                        if (e_row == 12'd0) begin
                            do_done = 1'b1;
                        end else begin
                            n_row   = e_row - 12'd1;
                            n_phase = PH_COUNT;
                        end
                    end else if (i_data_byte == 8'd1) begin
                        do_done = 1'b1;
                    end else if (i_data_byte == 8'd2) begin
                        n_phase = PH_DX;
                    end else begin
                        // absolute run; pad when the data byte count is odd
                        n_run   = i_data_byte;
                        n_pad   = i_cfg.nibble ? b_inc[1] : i_data_byte[0];
                        n_phase = PH_ABS;
                    end
                end
                PH_DX: begin
                    n_dx    = i_data_byte;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    nc    = {1'b0, e_col} + {6'd0, e_dx};
                    n_col = (nc > {1'b0, w}) ? w : nc[12:0];
                    if ({4'd0, i_data_byte} > e_row) begin
                        do_done = 1'b1;
                    end else begin
                        n_row   = e_row - {4'd0, i_data_byte};
                        n_phase = PH_COUNT;
                    end
                end
                PH_ABS: begin
                    do_run = 1'b1;
                    if (i_cfg.nibble) begin
                        n_abs = (e_run < 8'd2) ? e_run : 8'd2;
                        fv    = {4'd0, hi};
                        sv    = lo;
                        alt   = 1'b1;
                    end else begin
                        n_abs = 8'd1;
                        fv    = i_data_byte;
                    end
                    cnt   = n_abs;
                    n_run = (e_run > n_abs) ? e_run - n_abs : 8'd0;
                    if (n_run == 8'd0) begin
                        n_phase = e_pad ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_COUNT;
                end
                default: n_phase = PH_COUNT;
            endcase
        end

        // run clipping against the row end
        col_c = (e_col > w) ? w : e_col;
        avail = w - col_c;
        cnt_x = {5'd0, cnt};
        len   = (cnt_x < avail) ? cnt : avail[7:0];
        if (do_run) begin
            n_col = (cnt_x > avail) ? w : col_c + cnt_x;
        end

        if (do_done) begin
            n_done  = 1'b1;
            n_phase = PH_COUNT;
        end

        o_res_valid = do_run || do_done;
        o_res       = '0;
        if (do_done) begin
            o_res.frame_done = 1'b1;
        end else begin
            o_res.row_index    = e_row;
            o_res.column_start = (len != 8'd0) ? col_c[11:0] : 12'd0;
            o_res.first_value  = fv;
            o_res.second_value = sv;
            o_res.run_length   = len;
            o_res.alternating  = alt;
            o_res.was_clipped  = (cnt > len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_row   <= '0;
            r_col   <= '0;
            r_run   <= '0;
            r_dx    <= '0;
            r_pad   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_run   <= n_run;
            r_dx    <= n_dx;
            r_pad   <= n_pad;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmprle_obuf.sv =====
// Output register with a skid stage between the parser and the result stream.
`default_nettype none

module bmprle_obuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire bmprle_pkg::t_result i_res,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_take,
    output bmprle_pkg::t_result      o_res
);
    import bmprle_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign pop     = r_main_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no push is possible while the skid slot is full
            if (pop) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule

`default_nettype wire
